// ===== src/mcbt_pkg.sv =====
// Shared types and constants for the multi-channel blink timer.
// No dependencies; used by every module in src.
package mcbt_pkg;

  localparam int unsigned DIGITS     = 4;
  localparam int unsigned REG_COUNT  = 4;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned BIT_CNT_W  = $clog2(CNT_W);
  localparam int unsigned ADDR_W     = $clog2(REG_COUNT) + 2;
  localparam int unsigned DATA_W     = 32;

  localparam logic [CNT_W-1:0]     COUNT_LAST = CNT_W'(1000000 - 1);
  localparam logic [PERIOD_W-1:0]  SCAN_DIV   = PERIOD_W'(5);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(CNT_W - 1);

  typedef logic [REG_COUNT-1:0][PERIOD_W-1:0] period_arr_t;

  typedef struct packed {
    logic clr;
    logic step;
  } lane_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_e;

endpackage

// ===== src/mcbt_regs.sv =====
// APB-style register file holding the per-digit blink half periods.
// Depends on mcbt_pkg.
module mcbt_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcbt_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcbt_pkg::DATA_W-1:0]   pwdata,
  output logic [mcbt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mcbt_pkg::period_arr_t         periods_o
);

  localparam int unsigned IDX_W = $clog2(mcbt_pkg::REG_COUNT);

  mcbt_pkg::period_arr_t periods_q;
  logic [IDX_W-1:0]      idx;

  assign idx    = paddr[mcbt_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = mcbt_pkg::DATA_W'(periods_q[idx]);
  assign periods_o = periods_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      periods_q[idx] <= pwdata[mcbt_pkg::PERIOD_W-1:0];
    end
  end

endmodule

// ===== src/mcbt_mod_lane.sv =====
// Bit-serial remainder lane: takes the dividend MSB first, one bit a cycle while step is set.
// Depends on mcbt_pkg.
module mcbt_mod_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mcbt_pkg::lane_ctrl_t            ctrl_i,
  input  logic                            bit_i,
  input  logic [mcbt_pkg::PERIOD_W-1:0]   div_i,
  output logic                            zero_o
);

  logic [mcbt_pkg::PERIOD_W-1:0] rem_q, rem_d;
  logic [mcbt_pkg::PERIOD_W:0]   shifted;
  logic [mcbt_pkg::PERIOD_W:0]   diff;

  always_comb begin
    shifted = {rem_q, bit_i};
    diff    = shifted - {1'b0, div_i};
    rem_d   = rem_q;
    if (ctrl_i.clr) begin
      rem_d = '0;
    end else if (ctrl_i.step) begin
      // restoring step: subtract when the partial remainder reaches the divisor
      if (shifted >= {1'b0, div_i}) begin
        rem_d = diff[mcbt_pkg::PERIOD_W-1:0];
      end else begin
        rem_d = shifted[mcbt_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign zero_o = (rem_q == '0);

endmodule

// ===== src/multi_channel_blink_timer.sv =====
// Multi-channel blink timer: tick counter, scan strobe and per-digit blink flags.
// A request with tick runs 20 bit-serial remainder steps in ST_CALC, then the
// update in ST_FINISH registers its result; a request without tick skips ST_CALC.
// The input stalls until the request is done; in ST_CALC the 20-bit count shifts
// one bit a cycle through the remainder lanes; ST_FINISH holds for a free output.
// Reset: count clears to 0, flags go to all ones, half periods clear to 0.
module multi_channel_blink_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          tick_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          scan_strobe_o,
  output logic [3:0]                    blink_flags_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcbt_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcbt_pkg::DATA_W-1:0]   pwdata,
  output logic [mcbt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  mcbt_pkg::state_e              state_q, state_d;
  mcbt_pkg::period_arr_t         periods;
  mcbt_pkg::lane_ctrl_t          lane_ctrl;
  logic [mcbt_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [mcbt_pkg::CNT_W-1:0]    cnt_sh_q, cnt_sh_d;
  logic [mcbt_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [mcbt_pkg::REG_COUNT-1:0] flags_q, flags_d;
  logic                          tick_q, tick_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_strobe_q, out_strobe_d;
  logic [mcbt_pkg::REG_COUNT-1:0] out_flags_q, out_flags_d;
  logic [mcbt_pkg::DIGITS-1:0]   digit_zero;
  logic                          scan_zero;
  logic                          accept;
  logic                          finish;

  mcbt_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .periods_o(periods)
  );

  mcbt_mod_lane u_scan_lane (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .bit_i (cnt_sh_q[mcbt_pkg::CNT_W-1]),
    .div_i (mcbt_pkg::SCAN_DIV),
    .zero_o(scan_zero)
  );

  for (genvar g = 0; g < mcbt_pkg::DIGITS; g++) begin : g_lane
    mcbt_mod_lane u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(lane_ctrl),
      .bit_i (cnt_sh_q[mcbt_pkg::CNT_W-1]),
      .div_i (periods[g]),
      .zero_o(digit_zero[g])
    );
  end

  assign in_stall_o = (state_q != mcbt_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cnt_sh_d     = cnt_sh_q;
    bit_cnt_d    = bit_cnt_q;
    flags_d      = flags_q;
    tick_d       = tick_q;
    out_strobe_d = out_strobe_q;
    out_flags_d  = out_flags_q;
    out_valid_d  = out_valid_q && out_stall_i;
    lane_ctrl    = '0;
    finish       = 1'b0;

    unique case (state_q)
      mcbt_pkg::ST_IDLE: begin
        if (accept) begin
          tick_d        = tick_i;
          cnt_sh_d      = cnt_q;
          bit_cnt_d     = '0;
          lane_ctrl.clr = 1'b1;
          state_d       = tick_i ? mcbt_pkg::ST_CALC : mcbt_pkg::ST_FINISH;
        end
      end
      mcbt_pkg::ST_CALC: begin
        // shift one count bit into every lane
        lane_ctrl.step = 1'b1;
        cnt_sh_d       = {cnt_sh_q[mcbt_pkg::CNT_W-2:0], 1'b0};
        bit_cnt_d      = bit_cnt_q + 1'b1;
        if (bit_cnt_q == mcbt_pkg::BIT_LAST) begin
          state_d = mcbt_pkg::ST_FINISH;
        end
      end
      mcbt_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          finish       = 1'b1;
          out_strobe_d = tick_q && scan_zero;
          if (tick_q) begin
            for (int i = 0; i < int'(mcbt_pkg::DIGITS); i++) begin
              if (periods[i] != '0 && digit_zero[i]) begin
                flags_d[i] = ~flags_q[i];
              end
            end
            cnt_d = (cnt_q >= mcbt_pkg::COUNT_LAST) ? '0 : cnt_q + 1'b1;
          end
          out_flags_d = flags_d;
          out_valid_d = 1'b1;
          state_d     = mcbt_pkg::ST_IDLE;
        end
      end
      default: state_d = mcbt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcbt_pkg::ST_IDLE;
      cnt_q       <= '0;
      flags_q     <= '1;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_sh_q     <= cnt_sh_d;
    tick_q       <= tick_d;
    out_strobe_q <= out_strobe_d;
    out_flags_q  <= out_flags_d;
  end

  assign out_valid_o   = out_valid_q;
  assign scan_strobe_o = out_strobe_q;
  assign blink_flags_o = out_flags_q[3:0];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mcbt_pkg::COUNT_LAST)
    else $error("tick count out of range");

  a_count_moves_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(finish))
    else $error("tick count changed outside the update cycle");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mcbt_pkg::ST_FINISH))
    else $error("result raised without an update cycle");

  a_calc_needs_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcbt_pkg::ST_CALC) |-> tick_q)
    else $error("remainder pass started for a request without tick");

endmodule

// ===== sim/blink_timer_checker.sv =====
// Checker for the multi-channel blink timer: mirrors the half periods, tick count
// and blink flags, predicts one result per request and compares every result.
// Depends on mcbt_pkg for widths and constants.
module blink_timer_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        tick_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        scan_strobe_i,
  input  logic [3:0]                  blink_flags_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [mcbt_pkg::ADDR_W-1:0] paddr_i,
  input  logic [mcbt_pkg::DATA_W-1:0] pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       strobe;
    logic [3:0] flags;
  } blink_result_t;

  mcbt_pkg::period_arr_t      half_periods;
  logic [mcbt_pkg::CNT_W-1:0] ms_count;
  logic [3:0]                 flag_bits;
  blink_result_t              expected_blinks[$];
  int                         fails = 0;

  // Apply one request to the mirrored state and return the result it gives.
  function automatic blink_result_t advance_timer(input logic tick);
    blink_result_t res;
    res.strobe = 1'b0;
    if (tick) begin
      res.strobe = (ms_count % mcbt_pkg::CNT_W'(mcbt_pkg::SCAN_DIV)) == '0;
      for (int d = 0; d < mcbt_pkg::DIGITS && d < mcbt_pkg::REG_COUNT; d++) begin
        if (half_periods[d] != '0 &&
            (ms_count % mcbt_pkg::CNT_W'(half_periods[d])) == '0)
          flag_bits[d] = ~flag_bits[d];
      end
      ms_count = (ms_count >= mcbt_pkg::COUNT_LAST) ? '0 : ms_count + 1'b1;
    end
    res.flags = flag_bits;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blink_result_t want;
    if (!rst_ni) begin
      half_periods = '0;
      ms_count     = '0;
      flag_bits    = '1;
      expected_blinks.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[mcbt_pkg::ADDR_W-1:2] < mcbt_pkg::REG_COUNT)
        half_periods[paddr_i[mcbt_pkg::ADDR_W-1:2]] = pwdata_i[mcbt_pkg::PERIOD_W-1:0];

      if (in_valid_i && !in_stall_i)
        expected_blinks.push_back(advance_timer(tick_i));

      if (out_valid_i && !out_stall_i) begin
        if (expected_blinks.size() == 0) begin
          $display("[%0t] unexpected result: scan_strobe %b blink_flags %b",
                   $time, scan_strobe_i, blink_flags_i);
          fails++;
        end else begin
          want = expected_blinks.pop_front();
          if (scan_strobe_i !== want.strobe) begin
            $display("[%0t] scan_strobe mismatch: expected %b actual %b",
                     $time, want.strobe, scan_strobe_i);
            fails++;
          end
          if (blink_flags_i !== want.flags) begin
            $display("[%0t] blink_flags mismatch: expected %b actual %b",
                     $time, want.flags, blink_flags_i);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= expected_blinks.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Top of the blink timer testbench: drives ticks, register writes and output
// stalls, and gives the verdict. Depends on mcbt_pkg, the RTL and blink_timer_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQS     = 155;
  localparam int HOLD_AT        = 250;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        tick_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        scan_strobe_o;
  logic [3:0]                  blink_flags_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mcbt_pkg::ADDR_W-1:0] paddr;
  logic [mcbt_pkg::DATA_W-1:0] pwdata;
  logic [mcbt_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  int                          fail_count;
  int                          pending;
  int                          idle_cycles = 0;
  int                          sent_reqs   = 0;
  logic                        send_burst  = 1'b0;
  logic                        rx_calm     = 1'b0;

  always #10 clk_i = ~clk_i;

  multi_channel_blink_timer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tick_i        (tick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scan_strobe_o (scan_strobe_o),
    .blink_flags_o (blink_flags_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  blink_timer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .tick_i        (tick_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scan_strobe_i (scan_strobe_o),
    .blink_flags_i (blink_flags_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input logic tick);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_reqs++;
    // switch between gapped and back-to-back stretches
    if (sent_reqs % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_periods(input mcbt_pkg::period_arr_t periods);
    for (int r = 0; r < mcbt_pkg::REG_COUNT; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= mcbt_pkg::ADDR_W'(r * 4);
      // junk in the upper half must be dropped by the register
      pwdata  <= {16'($urandom()), periods[r]};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [mcbt_pkg::PERIOD_W-1:0] draw_half_period();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return mcbt_pkg::PERIOD_W'($urandom_range(1, 10));
    else if (pick < 65) return mcbt_pkg::PERIOD_W'($urandom_range(11, 300));
    else if (pick < 80) return '0;
    else if (pick < 90) return '1;
    else return mcbt_pkg::PERIOD_W'($urandom());
  endfunction

  initial begin : result_sink
    int stall_len;
    int taken;
    taken = 0;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      stall_len = rx_calm ? 0 : $urandom_range(0, 15);
      // hold off long enough for the block to back up into its input
      if (taken == HOLD_AT) stall_len = HOLD_CYCLES;
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
      if (taken % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    mcbt_pkg::period_arr_t periods;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    tick_i     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blinking disabled: no-tick requests and ticks across two scan strobes
    send_tick(1'b0);
    repeat (6) send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // fastest toggle, two short periods and the longest period
    periods[0] = mcbt_pkg::PERIOD_W'(1);
    periods[1] = mcbt_pkg::PERIOD_W'(2);
    periods[2] = mcbt_pkg::PERIOD_W'(3);
    periods[3] = '1;
    load_periods(periods);
    repeat (5) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    repeat (6) send_tick(1'b1);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int r = 0; r < mcbt_pkg::REG_COUNT; r++)
        periods[r] = (ph == 0) ? '1 : draw_half_period();
      load_periods(periods);
      repeat (PHASE_REQS) send_tick($urandom_range(0, 99) < 85);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
